@@ design/assert_macros.svh @@
// Assertion macros shared by the RTL; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property holds at every clock edge outside reset.
`define RFBA_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("rfba assertion failed");

// Condition never seen at a clock edge outside reset.
`define RFBA_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("rfba forbidden condition seen");

`else

`define RFBA_ASSERT(lbl, clk, rstn, prop)
`define RFBA_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

@@ design/rfba_pkg.sv @@
// Types and constants of the ring free-list block allocator.
package rfba_pkg;

    localparam int CNT_W     = 9;   // pool capacity and in-use count
    localparam int STRIDE_W  = 16;  // block size in bytes
    localparam int CFG_W     = 32;  // widest configuration register
    localparam int CFG_IDX_W = 2;
    localparam int ZERO_CAP  = 8;   // capacity used when the register is zero

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_CAPACITY = 2'd0;
    localparam t_cfg_idx CFG_STRIDE   = 2'd1;
    localparam t_cfg_idx CFG_BASE     = 2'd2;

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RECYCLE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_GRANT    = 2'd0,
        ST_EXHAUST  = 2'd1,
        ST_RECYCLED = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    // Record carried from the accept stage to the output stage
    typedef struct packed {
        t_status            status;
        logic [CNT_W-1:0]   in_use;
        logic               hit;     // ring entry was written since refill
    } t_s1;

endpackage

@@ design/rfba_ram.sv @@
// Generic simple dual-port RAM with registered read.
module rfba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

@@ design/ring_free_list_block_allocator.sv @@
// Top level of the ring free-list block allocator.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------------
//  cfg     | in        | i_cfg_we                | i_cfg_index, i_cfg_data
//  in      | in        | i_in_valid / o_in_stall | i_operation, i_returned_address
//  out     | out       | o_out_valid/i_out_stall | o_granted_address, o_status, o_in_use
//
// One transfer per cycle on in and out while neither side is stalled; a result passes the
// registered RAM read (accept stage), then the output register.
// Reset and every register write take effect at once: a fill count marks which ring
// entries were written since, unwritten entries read as base + index * stride.
// No clearing pass. A stalled output holds one result plus one in flight, then o_in_stall.
`include "assert_macros.svh"

module ring_free_list_block_allocator #(
    parameter int RING_DEPTH = 256,
    parameter int ADDR_BITS  = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rfba_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rfba_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  rfba_pkg::t_op                     i_operation,
    input  logic [ADDR_BITS-1:0]              i_returned_address,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [ADDR_BITS-1:0]              o_granted_address,
    output rfba_pkg::t_status                 o_status,
    output logic [rfba_pkg::CNT_W-1:0]        o_in_use
);

    import rfba_pkg::*;

    localparam int PTR_W   = $clog2(RING_DEPTH);
    localparam int FILL_W  = PTR_W + 1;
    localparam int CMP_W   = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;
    localparam int CNT_MAX = (1 << CNT_W) - 1;
    localparam int CAP_LIM = (RING_DEPTH > CNT_MAX) ? CNT_MAX : RING_DEPTH;
    localparam int PROD_W  = PTR_W + STRIDE_W;

    // configuration
    logic [CNT_W-1:0]    r_cap;
    logic [STRIDE_W-1:0] r_stride;
    logic [CFG_W-1:0]    r_base;

    // allocator state
    logic [PTR_W-1:0]    r_take, n_take;
    logic [PTR_W-1:0]    r_give, n_give;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [FILL_W-1:0]   r_fill, n_fill;

    // accept stage
    logic                r_s1_valid;
    t_s1                 r_s1, n_s1;
    logic [PROD_W-1:0]   r_s1_prod;

    // output stage
    logic                r_out_valid;
    logic [ADDR_BITS-1:0] r_out_addr, n_out_addr;
    t_status             r_out_status;
    logic [CNT_W-1:0]    r_out_count;

    logic [CNT_W-1:0]    cap_raw, eff_cap;
    logic [CMP_W-1:0]    cap_x, take_inc, give_inc;
    logic                out_free, s1_free, s1_move, in_acc;
    logic                is_alloc, do_grant, do_recycle;
    logic                refill;
    logic                ram_we, ram_re;
    logic [ADDR_BITS-1:0] ram_q, calc_addr;
    logic                out_not_grant;

    // effective capacity: zero means the default, capped by ring depth and by the largest count
    assign cap_raw = (r_cap == '0) ? CNT_W'(ZERO_CAP) : r_cap;
    assign eff_cap = (cap_raw > CNT_W'(CAP_LIM)) ? CNT_W'(CAP_LIM) : cap_raw;
    assign cap_x   = CMP_W'(eff_cap);

    assign take_inc = CMP_W'(r_take) + CMP_W'(1);
    assign give_inc = CMP_W'(r_give) + CMP_W'(1);

    assign out_free = !r_out_valid || !i_out_stall;
    assign s1_move  = r_s1_valid && out_free;
    assign s1_free  = !r_s1_valid || out_free;
    assign in_acc   = i_in_valid && s1_free;
    assign o_in_stall = !s1_free;

    assign is_alloc   = (i_operation == OP_ALLOC);
    assign do_grant   = is_alloc && (r_count < eff_cap);
    assign do_recycle = !is_alloc && (r_count != '0);

    assign ram_we = in_acc && do_recycle;
    assign ram_re = in_acc && do_grant;

    assign refill = i_cfg_we && ((i_cfg_index == CFG_CAPACITY) ||
                                 (i_cfg_index == CFG_STRIDE) ||
                                 (i_cfg_index == CFG_BASE));

    always_comb begin
        n_take  = r_take;
        n_give  = r_give;
        n_count = r_count;
        n_fill  = r_fill;
        if (in_acc && do_grant) begin
            n_take  = (take_inc >= cap_x) ? '0 : PTR_W'(take_inc);
            n_count = r_count + CNT_W'(1);
        end
        if (in_acc && do_recycle) begin
            n_give  = (give_inc >= cap_x) ? '0 : PTR_W'(give_inc);
            n_count = r_count - CNT_W'(1);
            // give pointer walks up from zero, so written entries form a prefix
            if (FILL_W'(r_give) >= r_fill) begin
                n_fill = FILL_W'(r_give) + FILL_W'(1);
            end
        end
        if (refill) begin
            n_take  = '0;
            n_give  = '0;
            n_count = '0;
            n_fill  = '0;
        end
    end

    always_comb begin
        n_s1.in_use = n_count;
        n_s1.hit    = (FILL_W'(r_take) < r_fill);
        if (is_alloc) begin
            n_s1.status = do_grant ? ST_GRANT : ST_EXHAUST;
        end else begin
            n_s1.status = do_recycle ? ST_RECYCLED : ST_EMPTY;
        end
    end

    // address of a never-written entry
    assign calc_addr = ADDR_BITS'(r_base) + ADDR_BITS'(r_s1_prod);

    always_comb begin
        n_out_addr = '0;
        if (r_s1.status == ST_GRANT) begin
            n_out_addr = r_s1.hit ? ram_q : calc_addr;
        end
    end

    rfba_ram #(
        .WIDTH (ADDR_BITS),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_give),
        .i_wdata (i_returned_address),
        .i_re    (ram_re),
        .i_raddr (r_take),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CNT_W'(ZERO_CAP);
            r_stride    <= STRIDE_W'(64);
            r_base      <= '0;
            r_take      <= '0;
            r_give      <= '0;
            r_count     <= '0;
            r_fill      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CAPACITY: r_cap    <= i_cfg_data[CNT_W-1:0];
                    CFG_STRIDE:   r_stride <= i_cfg_data[STRIDE_W-1:0];
                    CFG_BASE:     r_base   <= i_cfg_data;
                    default:      ;
                endcase
            end
            r_take  <= n_take;
            r_give  <= n_give;
            r_count <= n_count;
            r_fill  <= n_fill;
            if (s1_free) begin
                r_s1_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1      <= n_s1;
            r_s1_prod <= PROD_W'(r_take) * PROD_W'(r_stride);
        end
        if (s1_move) begin
            r_out_addr   <= n_out_addr;
            r_out_status <= r_s1.status;
            r_out_count  <= r_s1.in_use;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_granted_address = r_out_addr;
    assign o_status          = r_out_status;
    assign o_in_use          = r_out_count;

    assign out_not_grant = r_out_valid && (r_out_status != ST_GRANT);

    `RFBA_ASSERT(a_count_le_cap, i_clk, i_rst_n, r_count <= eff_cap)
    `RFBA_ASSERT(a_fill_le_cap, i_clk, i_rst_n, CMP_W'(r_fill) <= cap_x)
    `RFBA_ASSERT(a_addr_zero_unless_grant, i_clk, i_rst_n, out_not_grant |-> (r_out_addr == '0))
    `RFBA_ASSERT_NEVER(a_no_accept_when_full, i_clk, i_rst_n, in_acc && o_in_stall)

endmodule
